### sv/ibd_pkg.sv
`default_nettype none

package ibd_pkg;

  // Number of fields in one indoor bike data packet.
  localparam int NUM_FIELDS = 15;

  // Index one past the last field; marks "no field" in run bounds.
  localparam logic [3:0] FIELD_NONE = 4'd15;

  // Number of flag bits that select fields (bits 13 to 15 are unused).
  localparam int FLAG_BITS = 13;

  // Scale kinds: how a raw value becomes tenths of its unit.
  localparam logic [1:0] SCALE_HUNDREDTHS = 2'd0;
  localparam logic [1:0] SCALE_HALVES     = 2'd1;
  localparam logic [1:0] SCALE_UNITS      = 2'd2;
  localparam logic [1:0] SCALE_TENTHS     = 2'd3;

  // Division by ten as multiply by reciprocal; exact for inputs below 2**22.
  localparam logic [19:0] RECIP_TEN_MUL   = 20'd838861;
  localparam int          RECIP_TEN_SHIFT = 23;

  // One run of results handed from the parser to the result sequencer.
  // Fields start_field up to end_field - 1 are emitted. The first one carries
  // raw as a present value when first_present is set; the others are absent,
  // and marked truncated from trunc_from on.
  typedef struct packed {
    logic [23:0] raw;
    logic        first_present;
    logic [3:0]  trunc_from;
    logic [3:0]  end_field;
    logic [3:0]  start_field;
  } cmd_t;

  // Flag bit that controls each field; fields 8 to 10 share bit 8.
  function automatic logic [3:0] flag_bit(input logic [3:0] f);
    logic [3:0] b;
    case (f)
      4'd9:    b = 4'd8;
      4'd10:   b = 4'd8;
      4'd11:   b = 4'd9;
      4'd12:   b = 4'd10;
      4'd13:   b = 4'd11;
      4'd14:   b = 4'd12;
      default: b = f;
    endcase
    return b;
  endfunction

  // Flag value that means present; speed is present when its bit is clear.
  function automatic logic enabled_pol(input logic [3:0] f);
    return (f != 4'd0);
  endfunction

  // Number of little-endian bytes a field occupies.
  function automatic logic [1:0] field_size(input logic [3:0] f);
    logic [1:0] s;
    case (f)
      4'd4:    s = 2'd3;
      4'd10:   s = 2'd1;
      4'd11:   s = 2'd1;
      4'd12:   s = 2'd1;
      default: s = 2'd2;
    endcase
    return s;
  endfunction

  // Fields holding two's complement values.
  function automatic logic field_signed(input logic [3:0] f);
    return (f == 4'd5) || (f == 4'd6) || (f == 4'd7);
  endfunction

  function automatic logic [1:0] scale_kind(input logic [3:0] f);
    logic [1:0] k;
    case (f)
      4'd0:    k = SCALE_HUNDREDTHS;
      4'd1:    k = SCALE_HUNDREDTHS;
      4'd2:    k = SCALE_HALVES;
      4'd3:    k = SCALE_HALVES;
      4'd12:   k = SCALE_TENTHS;
      default: k = SCALE_UNITS;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### sv/indoor_bike_data_field_decoder.sv
// Flow: an accepted input word is parsed combinationally and its result run is written to the run
// queue; the result sequencer then loads each result word of the run into its output register.
// Throughput: one input word per cycle while the run queue is not full, and one result word per
// cycle while out_tready allows; a word that opens a run of k results occupies the result sequencer
// for all k result words, and the run queue of QUEUE_DEPTH entries lets the parser keep taking words meanwhile.
// Reset: synchronous, active low; the parser returns to awaiting the flags and the run queue empties.
`default_nettype none

module indoor_bike_data_field_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_packet
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // [3:0] field_index, [32:4] value_tenths, zero above
  output      logic [1:0]  out_tuser,  // [0] present, [1] truncated
  output      logic        out_tlast   // last_field
);

  logic          in_fire;
  logic          cmd_push;
  ibd_pkg::cmd_t cmd_data;
  ibd_pkg::cmd_t head;
  logic          q_empty;
  logic          q_full;
  logic          q_pop;
  logic [3:0]    res_index;
  logic          res_present;
  logic [28:0]   res_value;
  logic          res_trunc;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  ibd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .in_eop   (in_tlast),
    .cmd_push (cmd_push),
    .cmd_data (cmd_data)
  );

  ibd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_data),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  ibd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (q_empty),
    .pop         (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_index   (res_index),
    .out_present (res_present),
    .out_value   (res_value),
    .out_trunc   (res_trunc),
    .out_last    (out_tlast)
  );

  assign out_tdata = {7'd0, res_value, res_index};
  assign out_tuser = {res_trunc, res_present};

endmodule

`default_nettype wire

### sv/ibd_front.sv
`default_nettype none

module ibd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_eop,
  output      logic              cmd_push,
  output      ibd_pkg::cmd_t     cmd_data
);

  // Parser phases.
  localparam logic [1:0] PH_LOW    = 2'd0;
  localparam logic [1:0] PH_HIGH   = 2'd1;
  localparam logic [1:0] PH_FIELDS = 2'd2;

  logic [1:0]                    phase_r, phase_nxt;
  logic [ibd_pkg::FLAG_BITS-1:0] flags_r, flags_nxt;
  logic [3:0]                    cur_r, cur_nxt;
  logic [1:0]                    cnt_r, cnt_nxt;
  logic [23:0]                   acc_r, acc_nxt;
  logic                          done_r, done_nxt;

  logic [ibd_pkg::FLAG_BITS-1:0] full_flags;
  logic [3:0]                    np_hdr;
  logic [3:0]                    np_fld;
  logic [23:0]                   acc_new;
  logic [1:0]                    cnt_inc;
  logic                          complete;

  function automatic logic field_present(input logic [ibd_pkg::FLAG_BITS-1:0] flags,
                                         input logic [3:0] f);
    return flags[ibd_pkg::flag_bit(f)] == ibd_pkg::enabled_pol(f);
  endfunction

  // First present field at or after 'from', or FIELD_NONE.
  function automatic logic [3:0] next_present(input logic [ibd_pkg::FLAG_BITS-1:0] flags,
                                              input logic [4:0] from);
    logic [3:0] res;
    res = ibd_pkg::FIELD_NONE;
    for (int f = ibd_pkg::NUM_FIELDS - 1; f >= 0; f--) begin
      if ((5'(f) >= from) && field_present(flags, 4'(f))) begin
        res = 4'(f);
      end
    end
    return res;
  endfunction

  function automatic ibd_pkg::cmd_t make_cmd(input logic [3:0] s, input logic [3:0] e,
                                             input logic [3:0] t, input logic p,
                                             input logic [23:0] raw);
    ibd_pkg::cmd_t c;
    c.start_field   = s;
    c.end_field     = e;
    c.trunc_from    = t;
    c.first_present = p;
    c.raw           = raw;
    return c;
  endfunction

  // Shared decode of the accepted word.
  assign full_flags = {in_byte[ibd_pkg::FLAG_BITS-9:0], flags_r[7:0]};
  assign np_hdr     = next_present(full_flags, 5'd0);
  assign np_fld     = next_present(flags_r, {1'b0, cur_r} + 5'd1);
  assign acc_new    = acc_r | ({16'd0, in_byte} << {cnt_r, 3'b000});
  assign cnt_inc    = cnt_r + 2'd1;
  assign complete   = (cnt_inc >= ibd_pkg::field_size(cur_r));

  // Parser: tracks the header, gathers field bytes and issues result runs.
  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    done_nxt  = done_r;
    cmd_push  = 1'b0;
    cmd_data  = make_cmd(4'd0, 4'd0, 4'd0, 1'b0, 24'd0);
    if (in_fire) begin
      case (phase_r)
        PH_LOW: begin
          flags_nxt[7:0] = in_byte;
          phase_nxt      = PH_HIGH;
          if (in_eop) begin
            cmd_push = 1'b1;
            cmd_data = make_cmd(4'd0, ibd_pkg::FIELD_NONE, 4'd0, 1'b0, 24'd0);
          end
        end
        PH_HIGH: begin
          flags_nxt = full_flags;
          phase_nxt = PH_FIELDS;
          cur_nxt   = np_hdr;
          done_nxt  = (np_hdr == ibd_pkg::FIELD_NONE);
          if (in_eop) begin
            cmd_push = 1'b1;
            cmd_data = make_cmd(4'd0, ibd_pkg::FIELD_NONE, np_hdr, 1'b0, 24'd0);
          end else if (np_hdr != 4'd0) begin
            cmd_push = 1'b1;
            cmd_data = make_cmd(4'd0, np_hdr, ibd_pkg::FIELD_NONE, 1'b0, 24'd0);
          end
        end
        default: begin
          if (!done_r) begin
            if (complete) begin
              cmd_push = 1'b1;
              cmd_data = make_cmd(cur_r, in_eop ? ibd_pkg::FIELD_NONE : np_fld,
                                  in_eop ? np_fld : ibd_pkg::FIELD_NONE, 1'b1, acc_new);
              cur_nxt  = np_fld;
              cnt_nxt  = 2'd0;
              acc_nxt  = 24'd0;
              done_nxt = (np_fld == ibd_pkg::FIELD_NONE);
            end else begin
              cnt_nxt = cnt_inc;
              acc_nxt = acc_new;
              if (in_eop) begin
                cmd_push = 1'b1;
                cmd_data = make_cmd(cur_r, ibd_pkg::FIELD_NONE, cur_r, 1'b0, 24'd0);
              end
            end
          end
        end
      endcase
      // End of packet returns the parser to its idle state.
      if (in_eop) begin
        phase_nxt = PH_LOW;
        flags_nxt = '0;
        cur_nxt   = 4'd0;
        cnt_nxt   = 2'd0;
        acc_nxt   = 24'd0;
        done_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOW;
      flags_r <= '0;
      cur_r   <= 4'd0;
      cnt_r   <= 2'd0;
      acc_r   <= 24'd0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/ibd_queue.sv
`default_nettype none

module ibd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ibd_pkg::cmd_t push_data,
  input  wire logic          pop,
  output      ibd_pkg::cmd_t head,
  output      logic          empty,
  output      logic          full
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ibd_pkg::cmd_t      slots_r [DEPTH];
  logic [IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = slots_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wrap_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? wrap_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### sv/ibd_back.sv
`default_nettype none

module ibd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ibd_pkg::cmd_t head,
  input  wire logic          empty,
  output      logic          pop,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      logic [3:0]    out_index,
  output      logic          out_present,
  output      logic [28:0]   out_value,
  output      logic          out_trunc,
  output      logic          out_last
);

  logic        busy_r, busy_nxt;
  logic [3:0]  f_r, f_nxt;
  logic        valid_r, valid_nxt;
  logic [3:0]  index_r;
  logic        present_r;
  logic [28:0] value_r;
  logic        trunc_r;

  logic [3:0]  cur_f;
  logic [3:0]  next_f;
  logic        load;
  logic        emit;
  logic        is_present;

  // Sign or zero extension by field size, then scaling to tenths.
  function automatic logic [28:0] scale_value(input logic [3:0] f, input logic [23:0] raw);
    logic [28:0] sx;
    logic [16:0] biased;
    logic [36:0] prod;
    logic [28:0] res;
    case (ibd_pkg::field_size(f))
      2'd1:    sx = {21'd0, raw[7:0]};
      2'd2:    sx = ibd_pkg::field_signed(f) ? {{13{raw[15]}}, raw[15:0]}
                                              : {13'd0, raw[15:0]};
      default: sx = {5'd0, raw};
    endcase
    biased = {1'b0, raw[15:0]} + 17'd5;
    prod   = {20'd0, biased} * {17'd0, ibd_pkg::RECIP_TEN_MUL};
    case (ibd_pkg::scale_kind(f))
      ibd_pkg::SCALE_HUNDREDTHS: res = {15'd0, prod[36:ibd_pkg::RECIP_TEN_SHIFT]};
      ibd_pkg::SCALE_HALVES:     res = (sx << 2) + sx;
      ibd_pkg::SCALE_UNITS:      res = (sx << 3) + (sx << 1);
      default:                   res = sx;
    endcase
    return res;
  endfunction

  // Walk the head run one field per cycle, while the output register can load, into the output register.
  assign cur_f      = busy_r ? f_r : head.start_field;
  assign next_f     = cur_f + 4'd1;
  assign load       = !valid_r || out_ready;
  assign emit       = !empty && load;
  assign pop        = emit && (next_f == head.end_field);
  assign is_present = head.first_present && (cur_f == head.start_field);

  always_comb begin
    busy_nxt  = busy_r;
    f_nxt     = f_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = emit;
    end
    if (emit) begin
      busy_nxt = !pop;
      f_nxt    = next_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      f_r     <= 4'd0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      f_r     <= f_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result word payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      index_r   <= cur_f;
      present_r <= is_present;
      value_r   <= is_present ? scale_value(cur_f, head.raw) : 29'd0;
      trunc_r   <= !is_present && (cur_f >= head.trunc_from);
    end
  end

  assign out_valid   = valid_r;
  assign out_index   = index_r;
  assign out_present = present_r;
  assign out_value   = value_r;
  assign out_trunc   = trunc_r;
  assign out_last    = (index_r == 4'(ibd_pkg::NUM_FIELDS - 1));

endmodule

`default_nettype wire
